@@ sv/scba_pkg.sv @@
// types and constants of the size class block allocator
// used by size_class_block_allocator; no dependencies
`timescale 1ns / 1ps
package scba_pkg;

  localparam int UNIT_BYTES      = 16;
  localparam int UNIT_SHIFT      = 4;
  localparam int MAX_BLOCK_BYTES = 640;
  localparam int SIZE_CLASSES    = 40;
  localparam int HEAP_BYTES      = 1048576;
  localparam int COUNT_MAX       = 65536;
  localparam int RESET_CHUNK     = 1024;

  localparam int ADDR_W  = 20;
  localparam int HEAP_W  = 21;
  localparam int CHUNK_W = 21;
  localparam int CNT_W   = 17;
  localparam int SIZE_W  = 16;
  localparam int CLS_W   = 6;
  localparam int SLOT_W  = ADDR_W - UNIT_SHIFT;
  localparam int BSIZE_W = CLS_W + 1 + UNIT_SHIFT;
  localparam int DCNT_W  = 5;

  typedef enum logic [1:0] {
    OP_ALLOC       = 2'd0,
    OP_FREE        = 2'd1,
    OP_CLEAR       = 2'd2,
    OP_CLEAR_RESET = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_ZERO   = 2'd1,
    ST_LARGE  = 2'd2,
    ST_NOHEAP = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_LINKRD,
    S_DIV,
    S_MUL,
    S_CHK,
    S_CARVE
  } state_e;

  typedef struct packed {
    op_e                operation;
    logic [SIZE_W-1:0]  request_bytes;
    logic [ADDR_W-1:0]  block_address;
  } req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] granted_address;
    status_e           status;
    logic [CNT_W-1:0]  blocks_in_use;
    logic [CNT_W-1:0]  chunks_made;
  } rsp_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  head;
    logic [CHUNK_W-1:0] chunk;
  } cls_entry_t;

  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] addr;
  } link_t;

endpackage

@@ sv/size_class_block_allocator.sv @@
// size class block allocator: free lists per class over a bump-pointer heap
// depends on scba_pkg
//
//  channel  signals                    direction  moves
//  req      req_valid req_stall req    in         one request (op, size, address)
//  rsp      rsp_valid rsp_stall rsp    out        one response per request
//  cfg      cfg_we cfg_wdata           in         initial chunk size
//
// one request at a time: clear and rejected sizes finish in idle, free in look,
// allocate from a non-empty list in the link read; an allocate that refills its
// class runs the bit-serial divider, multiply and heap check (stopping there when
// the heap runs out), then a walk writing one link per cycle to the link memory.
// reset (rst, synchronous) empties all lists and needs no clearing pass.
// requests stall while one is in work or a response waits; the next is taken after the response has left
`timescale 1ns / 1ps
module size_class_block_allocator
  import scba_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  req_t               req,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output rsp_t               rsp,
  input  logic               cfg_we,
  input  logic [CHUNK_W-1:0] cfg_wdata
);

  state_e state, state_next;

  logic [CHUNK_W-1:0] initial_chunk_bytes;
  logic [CHUNK_W-1:0] snap;
  logic [SIZE_CLASSES-1:0] hv;
  logic [SIZE_CLASSES-1:0] cv;
  logic [HEAP_W-1:0] heap_top;
  logic [CNT_W-1:0]  used;
  logic [CNT_W-1:0]  chunks;

  op_e                op_q;
  logic [CLS_W-1:0]   cls_q;
  logic [ADDR_W-1:0]  baddr_q;
  logic [ADDR_W-1:0]  head_q;
  logic [CHUNK_W-1:0] chunk_q;
  logic [BSIZE_W-1:0] bsize_q;
  logic [CHUNK_W-1:0] quo;
  logic [BSIZE_W-1:0] rem;
  logic [DCNT_W-1:0]  div_cnt;
  logic [CHUNK_W-1:0] cap_q;
  logic [HEAP_W-1:0]  need_q;
  logic [HEAP_W-1:0]  carve_addr;
  logic [CHUNK_W-1:0] carve_left;

  // memories
  cls_entry_t cls_mem [SIZE_CLASSES];
  link_t      link_mem [HEAP_BYTES / UNIT_BYTES];
  cls_entry_t cls_rdata;
  link_t      link_rdata;
  logic [CLS_W-1:0]  cls_raddr;
  logic [SLOT_W-1:0] link_raddr;
  logic              cls_we;
  cls_entry_t        cls_wdata;
  logic              link_we;
  logic [SLOT_W-1:0] link_waddr;
  link_t             link_wdata;

  logic req_acc;
  logic [SIZE_W-1:0] size_m1;
  logic [SIZE_W-UNIT_SHIFT-1:0] in_cls_full;
  status_e in_status;

  logic [CHUNK_W-1:0] eff_chunk;
  logic [CHUNK_W:0]   grown_raw;
  logic [CHUNK_W-1:0] grown;
  logic [BSIZE_W:0]   div_trial;
  logic [HEAP_W:0]    heap_sum;
  logic [CHUNK_W+BSIZE_W-1:0] need_prod;
  logic [CHUNK_W-1:0] cap_fix;
  logic [CNT_W-1:0]   used_inc, used_dec, chunks_inc;

  logic               fin;
  logic [ADDR_W-1:0]  fin_addr;
  status_e            fin_status;
  logic [CNT_W-1:0]   used_next, chunks_next;
  logic               set_hv, hv_val, set_cv;

  assign req_acc   = req_valid && !req_stall;
  assign req_stall = (state != S_IDLE) || rsp_valid;

  // class = ceil(size / unit) - 1
  assign size_m1     = req.request_bytes - SIZE_W'(1);
  assign in_cls_full = size_m1[SIZE_W-1:UNIT_SHIFT];
  always_comb begin
    if (req.request_bytes == '0) begin
      in_status = ST_ZERO;
    end else if (req.request_bytes > SIZE_W'(MAX_BLOCK_BYTES) ||
                 in_cls_full >= (SIZE_W-UNIT_SHIFT)'(SIZE_CLASSES)) begin
      in_status = ST_LARGE;
    end else begin
      in_status = ST_OK;
    end
  end
  assign cls_raddr = in_cls_full[CLS_W-1:0];

  assign eff_chunk = cv[cls_q] ? cls_rdata.chunk : snap;
  assign grown_raw = {1'b0, eff_chunk} + {2'b0, eff_chunk[CHUNK_W-1:1]};
  assign grown     = (grown_raw > (CHUNK_W+1)'(HEAP_BYTES)) ? CHUNK_W'(HEAP_BYTES)
                                                          : grown_raw[CHUNK_W-1:0];
  assign div_trial = {rem, quo[CHUNK_W-1]} - {1'b0, bsize_q};
  assign cap_fix   = (quo == '0) ? CHUNK_W'(1) : quo;
  assign need_prod = cap_fix * bsize_q;
  assign heap_sum  = {1'b0, heap_top} + {1'b0, need_q};

  assign used_inc   = (used < CNT_W'(COUNT_MAX)) ? used + CNT_W'(1) : used;
  assign used_dec   = (used != '0) ? used - CNT_W'(1) : used;
  assign chunks_inc = (chunks < CNT_W'(COUNT_MAX)) ? chunks + CNT_W'(1) : chunks;

  assign link_raddr = cls_rdata.head[ADDR_W-1:UNIT_SHIFT];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    fin         = 1'b0;
    fin_addr    = '0;
    fin_status  = ST_OK;
    used_next   = used;
    chunks_next = chunks;
    cls_we      = 1'b0;
    cls_wdata   = '0;
    link_we     = 1'b0;
    link_waddr  = '0;
    link_wdata  = '0;
    set_hv      = 1'b0;
    hv_val      = 1'b0;
    set_cv      = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (req_acc) begin
          if (req.operation == OP_CLEAR || req.operation == OP_CLEAR_RESET) begin
            fin         = 1'b1;
            used_next   = '0;
            chunks_next = '0;
          end else if (in_status != ST_OK) begin
            fin        = 1'b1;
            fin_status = in_status;
          end else begin
            state_next = S_LOOK;
          end
        end
      end
      S_LOOK: begin
        if (op_q == OP_FREE) begin
          link_we    = 1'b1;
          link_waddr = baddr_q[ADDR_W-1:UNIT_SHIFT];
          link_wdata = '{valid: hv[cls_q], addr: cls_rdata.head};
          cls_we     = 1'b1;
          cls_wdata  = '{head: baddr_q, chunk: eff_chunk};
          set_hv     = 1'b1;
          hv_val     = 1'b1;
          set_cv     = 1'b1;
          used_next  = used_dec;
          fin        = 1'b1;
          state_next = S_IDLE;
        end else if (hv[cls_q]) begin
          state_next = S_LINKRD;
        end else begin
          state_next = S_DIV;
        end
      end
      S_LINKRD: begin
        // pop: head moves to the link of the block handed out
        cls_we     = 1'b1;
        cls_wdata  = '{head: link_rdata.addr, chunk: chunk_q};
        set_hv     = 1'b1;
        hv_val     = link_rdata.valid;
        set_cv     = 1'b1;
        used_next  = used_inc;
        fin        = 1'b1;
        fin_addr   = head_q;
        state_next = S_IDLE;
      end
      S_DIV: begin
        if (div_cnt == DCNT_W'(1)) begin
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        state_next = S_CHK;
      end
      S_CHK: begin
        if (heap_sum > (HEAP_W+1)'(HEAP_BYTES)) begin
          cls_we     = 1'b1;
          cls_wdata  = '{head: head_q, chunk: chunk_q};
          set_cv     = 1'b1;
          fin        = 1'b1;
          fin_status = ST_NOHEAP;
          state_next = S_IDLE;
        end else begin
          state_next = S_CARVE;
        end
      end
      S_CARVE: begin
        link_we    = 1'b1;
        link_waddr = carve_addr[ADDR_W-1:UNIT_SHIFT];
        if (carve_left > CHUNK_W'(1)) begin
          link_wdata = '{valid: 1'b1,
                         addr: ADDR_W'(carve_addr + HEAP_W'(bsize_q))};
        end
        if (carve_left == CHUNK_W'(1)) begin
          // last link written: hand out the first block of the chunk
          cls_we      = 1'b1;
          cls_wdata   = '{head: ADDR_W'(heap_top + HEAP_W'(bsize_q)), chunk: chunk_q};
          set_hv      = 1'b1;
          hv_val      = (cap_q > CHUNK_W'(1));
          set_cv      = 1'b1;
          used_next   = used_inc;
          chunks_next = chunks_inc;
          fin         = 1'b1;
          fin_addr    = heap_top[ADDR_W-1:0];
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      initial_chunk_bytes <= CHUNK_W'(RESET_CHUNK);
      snap      <= CHUNK_W'(RESET_CHUNK);
      hv        <= '0;
      cv        <= '0;
      heap_top  <= '0;
      used      <= '0;
      chunks    <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        initial_chunk_bytes <= cfg_wdata;
      end
      used   <= used_next;
      chunks <= chunks_next;
      if (set_hv) begin
        hv[cls_q] <= hv_val;
      end
      if (set_cv) begin
        cv[cls_q] <= 1'b1;
      end
      if (state == S_IDLE && req_acc &&
          (req.operation == OP_CLEAR || req.operation == OP_CLEAR_RESET)) begin
        hv       <= '0;
        heap_top <= '0;
        if (req.operation == OP_CLEAR_RESET) begin
          cv   <= '0;
          snap <= initial_chunk_bytes;
        end
      end
      if (state == S_CARVE && carve_left == CHUNK_W'(1)) begin
        heap_top <= heap_top + need_q;
      end
      if (fin) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (fin) begin
      rsp <= '{granted_address: fin_addr, status: fin_status,
               blocks_in_use: used_next, chunks_made: chunks_next};
    end
    case (state)
      S_IDLE: begin
        op_q    <= req.operation;
        cls_q   <= cls_raddr;
        baddr_q <= req.block_address;
      end
      S_LOOK: begin
        head_q  <= cls_rdata.head;
        chunk_q <= hv[cls_q] ? eff_chunk : grown;
        bsize_q <= {BSIZE_W'(cls_q) + BSIZE_W'(1)} << UNIT_SHIFT;
        quo     <= grown;
        rem     <= '0;
        div_cnt <= DCNT_W'(CHUNK_W);
      end
      S_DIV: begin
        // restoring division, one quotient bit per cycle
        if (!div_trial[BSIZE_W]) begin
          rem <= div_trial[BSIZE_W-1:0];
          quo <= {quo[CHUNK_W-2:0], 1'b1};
        end else begin
          rem <= {rem[BSIZE_W-2:0], quo[CHUNK_W-1]};
          quo <= {quo[CHUNK_W-2:0], 1'b0};
        end
        div_cnt <= div_cnt - DCNT_W'(1);
      end
      S_MUL: begin
        cap_q  <= cap_fix;
        need_q <= need_prod[HEAP_W-1:0];
      end
      S_CHK: begin
        carve_addr <= heap_top;
        carve_left <= cap_q;
      end
      S_CARVE: begin
        carve_addr <= carve_addr + HEAP_W'(bsize_q);
        carve_left <= carve_left - CHUNK_W'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    cls_rdata <= cls_mem[cls_raddr];
    if (cls_we) begin
      cls_mem[cls_q] <= cls_wdata;
    end
  end

  always_ff @(posedge clk) begin
    link_rdata <= link_mem[link_raddr];
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
  end

  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> req_stall)
    else $error("request taken while busy");

  a_used_max: assert property (@(posedge clk) disable iff (rst)
    used <= CNT_W'(COUNT_MAX))
    else $error("blocks in use beyond limit");

  a_clear_heap: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE && req_acc && req.operation == OP_CLEAR |=> heap_top == '0)
    else $error("heap not reset by clear");

  a_heap_bound: assert property (@(posedge clk) disable iff (rst)
    heap_top <= HEAP_W'(HEAP_BYTES))
    else $error("heap top past heap end");

endmodule
